// ----- hw/rtl/checked_signed_integer_alu_assert.svh -----
// assertion macros for the checked alu
`ifndef CHECKED_SIGNED_INTEGER_ALU_ASSERT_SVH
`define CHECKED_SIGNED_INTEGER_ALU_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define CSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/csalu_pkg.sv -----
`default_nettype none
package csalu_pkg;
    localparam int DataWidth = 64;
    localparam int OpWidth = 4;
    localparam int StWidth = 2;
    // divider stages: one quotient bit per stage
    localparam int DivStages = DataWidth;
    // cycles from the accepting edge to the edge that takes the result
    localparam int Latency = DivStages + 2;

    typedef logic [OpWidth-1:0] t_op;
    typedef logic [StWidth-1:0] t_status;

    localparam t_op OpOr  = 4'd0;
    localparam t_op OpAnd = 4'd1;
    localparam t_op OpEq  = 4'd2;
    localparam t_op OpNe  = 4'd3;
    localparam t_op OpLt  = 4'd4;
    localparam t_op OpLe  = 4'd5;
    localparam t_op OpGt  = 4'd6;
    localparam t_op OpGe  = 4'd7;
    localparam t_op OpAdd = 4'd8;
    localparam t_op OpSub = 4'd9;
    localparam t_op OpMul = 4'd10;
    localparam t_op OpDiv = 4'd11;
    localparam t_op OpRem = 4'd12;

    localparam t_status StOk   = 2'd0;
    localparam t_status StOvf  = 2'd1;
    localparam t_status StDivz = 2'd2;
endpackage
`default_nettype wire

// ----- hw/rtl/csalu_div.sv -----
`default_nettype none
// pipelined restoring divider on magnitudes, one quotient bit per stage
module csalu_div (
    input  wire logic                           i_clk,
    input  wire logic [csalu_pkg::DataWidth-1:0] i_num,
    input  wire logic [csalu_pkg::DataWidth-1:0] i_den,
    output logic      [csalu_pkg::DataWidth-1:0] o_quo,
    output logic      [csalu_pkg::DataWidth-1:0] o_rem
);
    import csalu_pkg::*;

    logic [DataWidth-1:0] r_num [DivStages+1];
    logic [DataWidth-1:0] r_den [DivStages+1];
    logic [DataWidth-1:0] r_rem [DivStages+1];

    always_comb begin
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_rem[0] = '0;
    end

    for (genvar s = 0; s < DivStages; s++) begin : g_stage
        logic [DataWidth:0]   n_trial;
        logic [DataWidth-1:0] n_shift;
        always_comb begin
            n_shift = {r_rem[s][DataWidth-2:0], r_num[s][DataWidth-1]};
            n_trial = {r_rem[s][DataWidth-1], n_shift} - {1'b0, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            r_den[s+1] <= r_den[s];
            if (!n_trial[DataWidth]) begin
                r_rem[s+1] <= n_trial[DataWidth-1:0];
                r_num[s+1] <= {r_num[s][DataWidth-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= n_shift;
                r_num[s+1] <= {r_num[s][DataWidth-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_num[DivStages];
    assign o_rem = r_rem[DivStages];
endmodule
`default_nettype wire

// ----- hw/rtl/checked_signed_integer_alu.sv -----
// channel | ports                                      | qualifier
// cmd     | i_op, i_left_operand, i_right_operand      | i_start && !o_busy
// result  | o_value, o_status                          | o_done (one cycle)
// a new word may be accepted every cycle; o_busy is always low
// o_done and the result come out through the input register, the 64-stage
// divider pipeline and the output register, and the result is taken at the edge
// given by Latency; other ops ride along in matching delay stages
// reset clears only the valid bits; the receiver cannot stall
`default_nettype none
module checked_signed_integer_alu (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [3:0]                       i_op,
    input  wire logic signed [63:0]               i_left_operand,
    input  wire logic signed [63:0]               i_right_operand,
    output logic                                  o_busy,
    output logic                                  o_done,
    output logic signed [63:0]                    o_value,
    output logic [1:0]                            o_status
);
    import csalu_pkg::*;

    localparam int W = DataWidth;
    localparam int H = W / 2;

    // stage 0: register magnitudes and simple ops
    logic            r0_v;
    t_op             r0_op;
    logic [W-1:0]    r0_a, r0_b, r0_ma, r0_mb;
    logic            r0_neg, r0_aneg;
    logic [W-1:0]    r0_simple;
    t_status         r0_sst;
    logic            n_acc;
    logic [W:0]      n_sum, n_dif;
    logic            n_lt, n_eq;
    logic [W-1:0]    n_simple;
    t_status         n_sst;

    assign o_busy = 1'b0;
    assign n_acc = i_start && !o_busy;

    always_comb begin
        n_sum = {i_left_operand[W-1], i_left_operand} + {i_right_operand[W-1], i_right_operand};
        n_dif = {i_left_operand[W-1], i_left_operand} - {i_right_operand[W-1], i_right_operand};
        n_eq = i_left_operand == i_right_operand;
        n_lt = n_dif[W];
        n_simple = '0;
        n_sst = StOk;
        case (i_op)
            OpOr:  n_simple = (i_left_operand != 0) ? i_left_operand : i_right_operand;
            OpAnd: n_simple = (i_left_operand != 0 && i_right_operand != 0) ? i_left_operand : '0;
            OpEq:  n_simple = W'(n_eq);
            OpNe:  n_simple = W'(!n_eq);
            OpLt:  n_simple = W'(n_lt);
            OpLe:  n_simple = W'(n_lt || n_eq);
            OpGt:  n_simple = W'(!n_lt && !n_eq);
            OpGe:  n_simple = W'(!n_lt);
            OpAdd: begin
                if (n_sum[W] != n_sum[W-1]) n_sst = StOvf;
                else n_simple = n_sum[W-1:0];
            end
            OpSub: begin
                if (n_dif[W] != n_dif[W-1]) n_sst = StOvf;
                else n_simple = n_dif[W-1:0];
            end
            default: n_simple = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= n_acc;
        end
        r0_op     <= i_op;
        r0_a      <= i_left_operand;
        r0_b      <= i_right_operand;
        r0_ma     <= i_left_operand[W-1] ? -i_left_operand : i_left_operand;
        r0_mb     <= i_right_operand[W-1] ? -i_right_operand : i_right_operand;
        r0_neg    <= i_left_operand[W-1] ^ i_right_operand[W-1];
        r0_aneg   <= i_left_operand[W-1];
        r0_simple <= n_simple;
        r0_sst    <= n_sst;
    end

    // multiplier: four 32x32 partial products, registered, then summed in stages
    logic [W-1:0] r1_pll, r1_plh, r1_phl, r1_phh;
    always_ff @(posedge i_clk) begin
        r1_pll <= r0_ma[H-1:0] * r0_mb[H-1:0];
        r1_plh <= r0_ma[H-1:0] * r0_mb[W-1:H];
        r1_phl <= r0_ma[W-1:H] * r0_mb[H-1:0];
        r1_phh <= r0_ma[W-1:H] * r0_mb[W-1:H];
    end
    logic [W-1:0] r2_lo;
    logic [W:0]   r2_mid;
    logic [W-1:0] r2_hi;
    always_ff @(posedge i_clk) begin
        r2_lo  <= r1_pll;
        r2_mid <= {1'b0, r1_plh} + {1'b0, r1_phl};
        r2_hi  <= r1_phh;
    end
    logic [W:0]   n_low;
    logic [W-1:0] n_high;
    logic [W-1:0] r3_prod;
    logic         r3_big;
    always_comb begin
        n_low  = {1'b0, r2_lo} + {1'b0, r2_mid[H-1:0], {H{1'b0}}};
        n_high = r2_hi + W'(r2_mid[W:H]) + W'(n_low[W]);
    end
    always_ff @(posedge i_clk) begin
        r3_prod <= n_low[W-1:0];
        r3_big  <= n_high != 0;
    end

    // divider pipeline on magnitudes
    logic [W-1:0] w_quo, w_rem;
    csalu_div u_div (
        .i_clk (i_clk),
        .i_num (r0_ma),
        .i_den (r0_mb),
        .o_quo (w_quo),
        .o_rem (w_rem)
    );

    // delay line for control, simple results and the product, matched to the divider
    logic         r_v    [DivStages+1];
    t_op          r_op   [DivStages+1];
    logic         r_neg  [DivStages+1];
    logic         r_aneg [DivStages+1];
    logic         r_bz   [DivStages+1];
    logic         r_dovf [DivStages+1];
    logic [W-1:0] r_simp [DivStages+1];
    t_status      r_sst  [DivStages+1];
    logic [W-1:0] r_mul  [DivStages+1];
    logic         r_movf [DivStages+1];

    always_comb begin
        r_v[0]    = r0_v;
        r_op[0]   = r0_op;
        r_neg[0]  = r0_neg;
        r_aneg[0] = r0_aneg;
        r_bz[0]   = r0_b == 0;
        r_dovf[0] = r0_a == {1'b1, {(W-1){1'b0}}} && r0_b == {W{1'b1}};
        r_simp[0] = r0_simple;
        r_sst[0]  = r0_sst;
        r_mul[0]  = '0;
        r_movf[0] = 1'b0;
    end

    // multiply overflow check once the product is ready
    logic n_movf;
    assign n_movf = r3_big || (r_neg[3]
        ? (r3_prod > {1'b1, {(W-1){1'b0}}}) : r3_prod[W-1]);

    for (genvar s = 0; s < DivStages; s++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_op[s+1]   <= r_op[s];
            r_neg[s+1]  <= r_neg[s];
            r_aneg[s+1] <= r_aneg[s];
            r_bz[s+1]   <= r_bz[s];
            r_dovf[s+1] <= r_dovf[s];
            r_simp[s+1] <= r_simp[s];
            r_sst[s+1]  <= r_sst[s];
            if (s == 3) begin
                r_mul[s+1]  <= r_neg[3] ? -r3_prod : r3_prod;
                r_movf[s+1] <= n_movf;
            end else begin
                r_mul[s+1]  <= r_mul[s];
                r_movf[s+1] <= r_movf[s];
            end
        end
    end

    // final selection and output register
    logic [W-1:0] n_val;
    t_status      n_st;
    localparam int L = DivStages;
    always_comb begin
        n_val = r_simp[L];
        n_st  = r_sst[L];
        case (r_op[L])
            OpMul: begin
                n_st  = r_movf[L] ? StOvf : StOk;
                n_val = r_movf[L] ? '0 : r_mul[L];
            end
            OpDiv: begin
                n_st  = r_bz[L] ? StDivz : (r_dovf[L] ? StOvf : StOk);
                n_val = (n_st != StOk) ? '0 : (r_neg[L] ? -w_quo : w_quo);
            end
            OpRem: begin
                n_st  = r_bz[L] ? StDivz : StOk;
                n_val = r_bz[L] ? '0 : (r_aneg[L] ? -w_rem : w_rem);
            end
            default: n_val = r_simp[L];
        endcase
    end

    logic          r_done;
    logic [W-1:0]  r_val;
    t_status       r_st;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v[L];
        end
        r_val <= n_val;
        r_st  <= n_st;
    end

    assign o_done   = r_done;
    assign o_value  = r_val;
    assign o_status = r_st;
endmodule
`default_nettype wire

// ----- hw/rtl/csalu_checker.sv -----
`default_nettype none
`include "checked_signed_integer_alu_assert.svh"
module csalu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic        o_done,
    input wire logic [63:0] o_value,
    input wire logic [1:0]  o_status
);
    import csalu_pkg::*;

    `CSA_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_done, o_status != 2'd3)
    `CSA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_done && o_status != StOk, o_value == 0)
    `CSA_ASSERT_IMP(a_never_busy, i_clk, i_rst_n, 1'b1, !o_busy)
    `CSA_ASSERT_IMP(a_done_latency, i_clk, i_rst_n, o_done,
        $past(i_start, Latency) && $past(i_rst_n, Latency))
endmodule

bind checked_signed_integer_alu csalu_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_value  (o_value),
    .o_status (o_status)
);
`default_nettype wire

// ----- verif/checked_signed_integer_alu_test.sv -----
`default_nettype none
module checked_signed_integer_alu_test;
    import csalu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // one command word as it goes to the block
    typedef struct packed {
        t_op         op;
        logic [63:0] left;
        logic [63:0] right;
    } t_alu_cmd;

    // one result word as the block should give it
    typedef struct packed {
        logic [63:0] value;
        t_status     status;
    } t_alu_res;

    localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] AllOnes = '1;
    localparam int CycleLimit = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic [3:0]        i_op;
    logic signed [63:0] i_left_operand;
    logic signed [63:0] i_right_operand;
    logic              o_busy;
    logic              o_done;
    logic signed [63:0] o_value;
    logic [1:0]        o_status;

    checked_signed_integer_alu dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_op(i_op),
        .i_left_operand(i_left_operand), .i_right_operand(i_right_operand),
        .o_busy(o_busy), .o_done(o_done), .o_value(o_value), .o_status(o_status)
    );

    t_alu_cmd pending_cmds[$];
    t_alu_res expected_results[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 13;
    bit       hold_sender = 0;
    bit       stimulus_done = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // magnitude of a two's complement word, min value maps to itself
    function automatic logic [63:0] magnitude(logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    // predicted value and status for one command word
    function automatic t_alu_res alu_predict(t_alu_cmd c);
        t_alu_res    res;
        logic [63:0] a, b, r, ma, mb, lim, q;
        logic        neg, lt, eq;
        a = c.left;
        b = c.right;
        r = '0;
        res.status = StOk;
        eq = (a == b);
        lt = ($signed(a) < $signed(b));
        case (c.op)
            OpOr:  r = (a != 0) ? a : b;
            OpAnd: r = (a != 0 && b != 0) ? a : 64'd0;
            OpEq:  r = {63'd0, eq};
            OpNe:  r = {63'd0, !eq};
            OpLt:  r = {63'd0, lt};
            OpLe:  r = {63'd0, lt || eq};
            OpGt:  r = {63'd0, !lt && !eq};
            OpGe:  r = {63'd0, !lt};
            OpAdd: begin
                r = a + b;
                if (a[63] == b[63] && r[63] != a[63]) res.status = StOvf;
            end
            OpSub: begin
                r = a - b;
                if (a[63] != b[63] && r[63] != a[63]) res.status = StOvf;
            end
            OpMul: begin
                ma = magnitude(a);
                mb = magnitude(b);
                neg = a[63] != b[63];
                lim = neg ? MinVal : MaxVal;
                if (ma == 0 || mb == 0) r = '0;
                else if (mb > lim / ma) res.status = StOvf;
                else begin
                    q = ma * mb;
                    r = neg ? 64'd0 - q : q;
                end
            end
            OpDiv: begin
                if (b == 0) res.status = StDivz;
                else if (a == MinVal && b == AllOnes) res.status = StOvf;
                else begin
                    q = magnitude(a) / magnitude(b);
                    r = (a[63] != b[63]) ? 64'd0 - q : q;
                end
            end
            OpRem: begin
                if (b == 0) res.status = StDivz;
                else begin
                    q = magnitude(a) % magnitude(b);
                    r = a[63] ? 64'd0 - q : q;
                end
            end
            default: r = '0;
        endcase
        if (res.status != StOk) r = '0;
        res.value = r;
        return res;
    endfunction

    function automatic t_alu_cmd make_cmd(int op, logic [63:0] a, logic [63:0] b);
        t_alu_cmd c;
        c.op = t_op'(op);
        c.left = a;
        c.right = b;
        return c;
    endfunction

    // operand with a bias toward the corners and small values
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = MinVal;
            1: v = MaxVal;
            2: v = AllOnes;
            3: v = '0;
            4: v = 64'($signed($urandom_range(0, 40)) - 20);
            5: v = {32'd0, $urandom()};
            6: v = {{32{1'b1}}, $urandom()};
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // driver: hold a word until it is taken, idle at random between words
    always @(posedge i_clk) begin
        t_alu_cmd c;
        if (!i_rst_n) begin
            i_start <= 0;
        end else if (i_start && !o_busy) begin
            // current word is accepted at this edge
            expected_results.push_back(alu_predict({t_op'(i_op), i_left_operand,
                                                    i_right_operand}));
            if (pending_cmds.size() != 0 && !hold_sender &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                c = pending_cmds.pop_front();
                i_op <= c.op;
                i_left_operand <= c.left;
                i_right_operand <= c.right;
            end else begin
                i_start <= 0;
            end
        end else if (!i_start && pending_cmds.size() != 0 && !hold_sender &&
                     $urandom_range(0, 99) >= send_idle_pct) begin
            c = pending_cmds.pop_front();
            i_start <= 1;
            i_op <= c.op;
            i_left_operand <= c.left;
            i_right_operand <= c.right;
        end
    end

    // monitor: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        t_alu_res w;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", o_value, '0);
            end else begin
                w = expected_results.pop_front();
                if (o_value !== w.value) report_mismatch("value", o_value, w.value);
                if (o_status !== w.status)
                    report_mismatch("status", 64'(o_status), 64'(w.status));
            end
        end
    end

    // timeout guard
    always @(posedge i_clk) begin
        if (cycle_count >= CycleLimit) begin
            $display("checked_signed_integer_alu_test: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 0;
        i_start = 0;
        i_op = '0;
        i_left_operand = '0;
        i_right_operand = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: each op at the corners
        for (int op = 0; op <= 12; op++)
            pending_cmds.push_back(make_cmd(op, MinVal, AllOnes));
        pending_cmds.push_back(make_cmd(OpDiv, 64'd5, 64'd0));
        pending_cmds.push_back(make_cmd(OpRem, MinVal, 64'd0));
        pending_cmds.push_back(make_cmd(OpAdd, MaxVal, 64'd1));
        pending_cmds.push_back(make_cmd(OpSub, MinVal, 64'd1));
        pending_cmds.push_back(make_cmd(OpMul, MaxVal, 64'd2));
        pending_cmds.push_back(make_cmd(OpMul, 64'h4000_0000_0000_0000, AllOnes - 1));
        pending_cmds.push_back(make_cmd(OpRem, -64'sd7, 64'd2));
        pending_cmds.push_back(make_cmd(OpOr, '0, '0));
        pending_cmds.push_back(make_cmd(OpAnd, 64'd3, '0));
        pending_cmds.push_back(make_cmd(13, MaxVal, MaxVal));
        pending_cmds.push_back(make_cmd(15, AllOnes, AllOnes));

        // random in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 53 : 0;
            for (int k = 0; k < 615; k++)
                pending_cmds.push_back(make_cmd(
                    ($urandom_range(0, 19) == 0) ? $urandom_range(13, 15)
                                                 : $urandom_range(0, 12),
                    pick_operand(), pick_operand()));
            wait (pending_cmds.size() == 0);
            if (ph == 0) begin
                // sender holds until the pipeline has drained
                hold_sender = 1;
                @(posedge i_clk);
                wait (!i_start && expected_results.size() == 0);
                hold_sender = 0;
            end
        end

        wait (pending_cmds.size() == 0);
        @(posedge i_clk);
        wait (!i_start && expected_results.size() == 0);
        repeat (Latency + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("checked_signed_integer_alu_test: PASS");
        end else begin
            $display("checked_signed_integer_alu_test: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/csalu_pkg.sv
hw/rtl/csalu_div.sv
hw/rtl/checked_signed_integer_alu.sv
hw/rtl/csalu_checker.sv
verif/checked_signed_integer_alu_test.sv
